>>> hw/rtl/sspg_pkg.sv
`default_nettype none
package sspg_pkg;

    localparam int SSPG_MAX_SEGMENTS = 16;

    // command codes
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_ARM    = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_SETPOS = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_NO_DECEL = 2'd3;

    // finish reasons
    localparam logic [1:0] FIN_NONE    = 2'd0;
    localparam logic [1:0] FIN_TARGET  = 2'd1;
    localparam logic [1:0] FIN_STOPPED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_HALF   = 2'd0;
    localparam logic [1:0] CFG_DIR_HIGH   = 2'd1;
    localparam logic [1:0] CFG_DIR_SETUP  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [3:0]         seg_index;
        logic [31:0]        seg_steps;
        logic [31:0]        seg_half_period;
        logic               move_forward;
        logic [4:0]         seg_count;
        logic [31:0]        total_steps;
        logic               decelerate;
        logic signed [31:0] new_position;
    } t_sspg_in;

    typedef struct packed {
        logic [1:0]         status_code;
        logic               step_level;
        logic               dir_level;
        logic               running;
        logic [1:0]         finish_reason;
        logic signed [31:0] position;
        logic [31:0]        steps_done;
        logic [31:0]        active_half_period;
    } t_sspg_out;

    typedef struct packed {
        logic [31:0] steps;
        logic [31:0] half;
    } t_sspg_seg;

    // controller -> datapath
    typedef struct packed {
        logic       exec;
        logic       arm_go;
        logic       rd_val;
        logic       chk;
        logic       commit;
        logic       out_load;
        logic [1:0] status;
    } t_sspg_ctl;

    // datapath -> controller
    typedef struct packed {
        logic running;
        logic pre_bad;
        logic chk_bad;
        logic chk_last;
        logic sum_ok;
    } t_sspg_sts;

endpackage
`default_nettype wire

>>> hw/rtl/sspg_ctrl.sv
`default_nettype none
module sspg_ctrl
    import sspg_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_cmd,
    input  wire logic       i_decelerate,
    input  wire t_sspg_sts  i_sts,
    output t_sspg_ctl       o_ctl,
    output logic            o_out_valid,
    input  wire logic       i_out_stall
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_VRD  = 2'd1;
    localparam logic [1:0] S_VCHK = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;
    logic       w_accept;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == S_IDLE) && w_out_free);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_ARM && !i_sts.running && !i_sts.pre_bad) begin
                        o_ctl.arm_go = 1'b1;
                        n_state      = S_VRD;
                    end else begin
                        o_ctl.exec     = 1'b1;
                        o_ctl.out_load = 1'b1;
                        case (i_cmd)
                            CMD_LOAD, CMD_SETPOS, CMD_CLEAR:
                                o_ctl.status = i_sts.running ? ST_BUSY : ST_OK;
                            CMD_ARM:
                                o_ctl.status = i_sts.running ? ST_BUSY : ST_INVALID;
                            CMD_STOP:
                                o_ctl.status = i_decelerate ? ST_NO_DECEL : ST_OK;
                            default:
                                o_ctl.status = ST_OK;
                        endcase
                    end
                end
            end
            S_VRD: begin
                o_ctl.rd_val = 1'b1;
                n_state      = S_VCHK;
            end
            S_VCHK: begin
                o_ctl.chk = 1'b1;
                if (i_sts.chk_bad) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.status   = ST_INVALID;
                    n_state        = S_IDLE;
                end else if (i_sts.chk_last) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.commit   = i_sts.sum_ok;
                    o_ctl.status   = i_sts.sum_ok ? ST_OK : ST_INVALID;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_VRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_ctl.out_load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/sspg_dp.sv
`default_nettype none
module sspg_dp
    import sspg_pkg::*;
#(
    parameter int MAX_SEGMENTS = SSPG_MAX_SEGMENTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_sspg_in    i_item,
    input  wire t_sspg_ctl   i_ctl,
    output t_sspg_sts        o_sts,
    output t_sspg_out        o_out_item,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    // configuration
    logic [31:0] r_min_half;
    logic        r_dir_high;
    logic [31:0] r_dir_setup;

    // segment table, one read port with registered data
    t_sspg_seg   r_mem [MAX_SEGMENTS];
    t_sspg_seg   r_rd;
    logic        w_we;
    logic [IW-1:0] w_waddr;
    logic [IW-1:0] w_raddr;

    // move state
    logic [4:0]         r_used, n_used;
    logic [IW-1:0]      r_cur, n_cur;
    logic [31:0]        r_cur_half, n_cur_half;
    logic [31:0]        r_cur_steps, n_cur_steps;
    logic [31:0]        r_sis, n_sis;
    logic [31:0]        r_emitted, n_emitted;
    logic signed [31:0] r_pos, n_pos;
    logic [32:0]        r_ticks, n_ticks;
    logic               r_running, n_running;
    logic               r_step_high, n_step_high;
    logic               r_dir, n_dir;
    logic               r_fwd, n_fwd;
    logic               r_fep, n_fep;
    logic [1:0]         r_reason, n_reason;

    // arm validation
    logic [4:0]    r_count, n_count;
    logic [31:0]   r_total, n_total;
    logic          r_arm_fwd, n_arm_fwd;
    logic [IW-1:0] r_idx, n_idx;
    logic [31:0]   r_sum, n_sum;

    logic [31:0] w_min_hp;
    logic [31:0] w_sis_inc;
    t_sspg_out   r_out;

    assign w_min_hp = (r_min_half == 32'd0) ? 32'd1 : r_min_half;
    assign w_sis_inc = r_sis + 32'd1;

    assign o_sts.running  = r_running;
    assign o_sts.pre_bad  = (i_item.seg_count == 5'd0)
                         || (32'(i_item.seg_count) > 32'(MAX_SEGMENTS))
                         || (i_item.total_steps == 32'd0);
    assign o_sts.chk_bad  = (r_rd.steps == 32'd0) || (r_rd.half < w_min_hp);
    assign o_sts.chk_last = (32'(r_idx) + 32'd1) >= 32'(r_count);
    assign o_sts.sum_ok   = (r_sum + r_rd.steps) == r_total;

    assign w_we    = i_ctl.exec && (i_item.cmd == CMD_LOAD) && !r_running
                  && (32'(i_item.seg_index) < 32'(MAX_SEGMENTS));
    assign w_waddr = IW'(i_item.seg_index);
    // while running the read port holds the entry after the current one
    assign w_raddr = i_ctl.rd_val ? r_idx : (n_cur + IW'(1));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= '{steps: i_item.seg_steps, half: i_item.seg_half_period};
        end
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        n_used      = r_used;
        n_cur       = r_cur;
        n_cur_half  = r_cur_half;
        n_cur_steps = r_cur_steps;
        n_sis       = r_sis;
        n_emitted   = r_emitted;
        n_pos       = r_pos;
        n_ticks     = r_ticks;
        n_running   = r_running;
        n_step_high = r_step_high;
        n_dir       = r_dir;
        n_fwd       = r_fwd;
        n_fep       = r_fep;
        n_reason    = r_reason;
        n_count     = r_count;
        n_total     = r_total;
        n_arm_fwd   = r_arm_fwd;
        n_idx       = r_idx;
        n_sum       = r_sum;

        if (i_ctl.arm_go) begin
            n_count   = i_item.seg_count;
            n_total   = i_item.total_steps;
            n_arm_fwd = i_item.move_forward;
            n_idx     = '0;
            n_sum     = 32'd0;
        end

        if (i_ctl.chk) begin
            if (r_idx == '0) begin
                n_cur_half  = r_rd.half;
                n_cur_steps = r_rd.steps;
            end
            n_sum = r_sum + r_rd.steps;
            n_idx = r_idx + IW'(1);
        end

        if (i_ctl.commit) begin
            n_used      = r_count;
            n_cur       = '0;
            n_sis       = 32'd0;
            n_emitted   = 32'd0;
            n_reason    = FIN_NONE;
            n_fwd       = r_arm_fwd;
            n_dir       = r_arm_fwd ? r_dir_high : !r_dir_high;
            n_step_high = 1'b0;
            n_fep       = 1'b0;
            n_running   = 1'b1;
            n_ticks     = 33'(r_dir_setup) + 33'(n_cur_half);
        end

        if (i_ctl.exec) begin
            case (i_item.cmd)
                CMD_STOP: begin
                    if (!i_item.decelerate && r_running) begin
                        n_step_high = 1'b0;
                        n_fep       = 1'b0;
                        n_running   = 1'b0;
                        n_reason    = FIN_STOPPED;
                    end
                end
                CMD_TICK: begin
                    if (r_running) begin
                        if (r_ticks <= 33'd1) begin
                            n_step_high = !r_step_high;
                            if (r_step_high) begin
                                // falling edge; the move ends here after its last step
                                if (r_fep) begin
                                    n_running = 1'b0;
                                    n_reason  = FIN_TARGET;
                                    n_fep     = 1'b0;
                                end else begin
                                    n_ticks = 33'(r_cur_half);
                                end
                            end else begin
                                n_pos     = r_fwd ? (r_pos + 32'sd1) : (r_pos - 32'sd1);
                                n_emitted = r_emitted + 32'd1;
                                n_sis     = w_sis_inc;
                                n_ticks   = 33'(r_cur_half);
                                if (w_sis_inc >= r_cur_steps) begin
                                    if ((32'(r_cur) + 32'd1) >= 32'(r_used)) begin
                                        n_fep = 1'b1;
                                    end else begin
                                        n_sis       = 32'd0;
                                        n_cur       = r_cur + IW'(1);
                                        n_cur_half  = r_rd.half;
                                        n_cur_steps = r_rd.steps;
                                        n_ticks     = 33'(r_rd.half);
                                    end
                                end
                            end
                        end else begin
                            n_ticks = r_ticks - 33'd1;
                        end
                    end
                end
                CMD_SETPOS: begin
                    if (!r_running) begin
                        n_pos = i_item.new_position;
                    end
                end
                CMD_CLEAR: begin
                    if (!r_running) begin
                        n_reason = FIN_NONE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_half  <= 32'd1;
            r_dir_high  <= 1'b1;
            r_dir_setup <= 32'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_HALF:  r_min_half  <= i_cfg_data;
                CFG_DIR_HIGH:  r_dir_high  <= i_cfg_data[0];
                CFG_DIR_SETUP: r_dir_setup <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= 5'd0;
            r_cur       <= '0;
            r_cur_half  <= 32'd0;
            r_cur_steps <= 32'd0;
            r_sis       <= 32'd0;
            r_emitted   <= 32'd0;
            r_pos       <= 32'sd0;
            r_ticks     <= 33'd0;
            r_running   <= 1'b0;
            r_step_high <= 1'b0;
            r_dir       <= 1'b0;
            r_fwd       <= 1'b0;
            r_fep       <= 1'b0;
            r_reason    <= FIN_NONE;
        end else begin
            r_used      <= n_used;
            r_cur       <= n_cur;
            r_cur_half  <= n_cur_half;
            r_cur_steps <= n_cur_steps;
            r_sis       <= n_sis;
            r_emitted   <= n_emitted;
            r_pos       <= n_pos;
            r_ticks     <= n_ticks;
            r_running   <= n_running;
            r_step_high <= n_step_high;
            r_dir       <= n_dir;
            r_fwd       <= n_fwd;
            r_fep       <= n_fep;
            r_reason    <= n_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_total   <= n_total;
        r_arm_fwd <= n_arm_fwd;
        r_idx     <= n_idx;
        r_sum     <= n_sum;
        if (i_ctl.out_load) begin
            r_out.status_code        <= i_ctl.status;
            r_out.step_level         <= n_step_high;
            r_out.dir_level          <= n_dir;
            r_out.running            <= n_running;
            r_out.finish_reason      <= n_reason;
            r_out.position           <= n_pos;
            r_out.steps_done         <= n_emitted;
            r_out.active_half_period <= n_running ? n_cur_half : 32'd0;
        end
    end

    assign o_out_item = r_out;

endmodule
`default_nettype wire

>>> hw/rtl/segmented_step_pulse_generator_unit.sv
`default_nettype none
// Step/direction pulse generator driven by a stream of command items, one result item
// per command. Every command is executed as soon as it is accepted, ticks included,
// so a tick can be accepted on every clock while the result register drains; the
// result shows the state after the command. The exception is an arm that passes its
// count and total checks: it walks the segment table through the table's single
// registered read port, reading and then checking each segment, so it holds the input
// until its result appears, stopping early when a segment fails its check.
// Configuration writes are taken at any time, meant for idle periods.
module segmented_step_pulse_generator_unit
    import sspg_pkg::*;
#(
    parameter int MAX_SEGMENTS = SSPG_MAX_SEGMENTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_sspg_in    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_sspg_out        o_out_item,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    t_sspg_ctl w_ctl;
    t_sspg_sts w_sts;

    sspg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_in_item.cmd),
        .i_decelerate (i_in_item.decelerate),
        .i_sts        (w_sts),
        .o_ctl        (w_ctl),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall)
    );

    sspg_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_item),
        .i_ctl      (w_ctl),
        .o_sts      (w_sts),
        .o_out_item (o_out_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule
`default_nettype wire
